// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, sampled on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define PQT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// same-cycle implication
`define PQT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PQT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/pqt_pkg.sv =====
// ----------------------------------------------------------------------------
// pqt_pkg
// shared types and constants of the priority queue table
// ----------------------------------------------------------------------------
package pqt_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int HANDLE_W    = 8;
	localparam int PRIO_W      = 8;
	localparam int COUNT_W     = 5;

	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [HANDLE_W-1:0] handle_t;
	typedef logic [PRIO_W-1:0]   prio_t;

	typedef enum logic [1:0] {
		OP_ENQ   = 2'd0,
		OP_DEQ   = 2'd1,
		OP_PURGE = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic {
		CMP_GT = 1'b0,
		CMP_EQ = 1'b1
	} cmp_mode_t;

	typedef struct packed {
		handle_t hnd;
		prio_t   pri;
	} entry_t;

	typedef struct packed {
		logic   we;
		idx_t   waddr;
		entry_t wdata;
		idx_t   raddr;
	} mem_req_t;

endpackage

// ===== rtl/core/pqt_store.sv =====
// ----------------------------------------------------------------------------
// pqt_store
// entry table: one write port, one registered read port
// ----------------------------------------------------------------------------
module pqt_store
	import pqt_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output entry_t   rd_data
);

	entry_t mem [QUEUE_DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[req.raddr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/pqt_cmp.sv =====
// ----------------------------------------------------------------------------
// pqt_cmp
// shared compare unit: priority greater-than or handle match
// ----------------------------------------------------------------------------
module pqt_cmp
	import pqt_pkg::*;
(
	input  cmp_mode_t mode,
	input  entry_t    cand,
	input  entry_t    pivot,
	output logic      hit
);

	always_comb begin
		unique case (mode)
			CMP_GT:  hit = cand.pri > pivot.pri;
			CMP_EQ:  hit = cand.hnd == pivot.hnd;
			default: hit = 1'b0;
		endcase
	end

endmodule

// ===== rtl/core/priority_queue_table_core.sv =====
// ----------------------------------------------------------------------------
// priority_queue_table_core
// Bounded priority queue of handle and priority entries kept in arrival
// order in a table with one write port and one registered read port.
// Enqueue writes the tail in the accept cycle unless the table is full, and
// passes its result through the done state to the output register. Dequeue
// and purge walk the table one entry per cycle through one shared compare
// unit, then close the gap by moving each later entry down one place at one
// entry per cycle. A purge that misses goes from the scan straight to the
// done state, and a dequeue or purge with nothing to scan skips the scan.
// The input is not ready while a transaction is in progress; a finished
// result waits in the output register, and a new transaction is accepted
// while it waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module priority_queue_table_core
	import pqt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [PRIO_W-1:0]   prio,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [HANDLE_W-1:0] out_handle,
	output logic [PRIO_W-1:0]   out_prio,
	output logic [COUNT_W-1:0]  count,
	output logic                is_empty
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_REMOVE = 5'b00100,
		S_SHIFT  = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t    state_q;
	cnt_t      cnt_q;
	op_t       op_q;
	handle_t   hnd_q;
	idx_t      idx_q;
	idx_t      wp_q;
	entry_t    best_q;
	status_t   res_status_q;
	logic      out_valid_q;
	status_t   out_status_q;
	entry_t    out_entry_q;
	cnt_t      out_cnt_q;

	mem_req_t  mem_req;
	entry_t    rd_data;
	cmp_mode_t cmp_mode;
	entry_t    cmp_pivot;
	logic      cmp_hit;
	logic      in_fire;
	logic      enq_ok;
	logic      full;
	logic      scan_last;
	logic      take_cur;
	logic      no_shift;
	logic      shift_last;
	logic      out_load;

	pqt_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	pqt_cmp u_cmp (
		.mode  (cmp_mode),
		.cand  (rd_data),
		.pivot (cmp_pivot),
		.hit   (cmp_hit)
	);

	assign in_ready   = state_q == S_IDLE;
	assign in_fire    = in_valid && in_ready;
	assign full       = cnt_q == cnt_t'(QUEUE_DEPTH);
	assign enq_ok     = in_fire && op_t'(op) == OP_ENQ && !full;
	assign scan_last  = (cnt_t'(idx_q) + cnt_t'(1)) == cnt_q;
	assign no_shift   = (cnt_t'(wp_q) + cnt_t'(1)) >= cnt_q;
	assign shift_last = (cnt_t'(wp_q) + cnt_t'(2)) == cnt_q;
	assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign cmp_mode   = (op_q == OP_DEQ) ? CMP_GT : CMP_EQ;
	assign cmp_pivot  = (op_q == OP_DEQ) ? best_q : entry_t'({hnd_q, PRIO_W'(0)});
	// first entry seeds the running maximum; ties keep the earlier one
	assign take_cur   = (idx_q == '0) || cmp_hit;

	always_comb begin
		mem_req = '0;
		unique case (state_q)
			S_IDLE: begin
				if (enq_ok) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = cnt_q[IDX_W-1:0];
					mem_req.wdata = entry_t'({handle, prio});
				end
			end
			S_SCAN:   mem_req.raddr = idx_q + idx_t'(1);
			S_REMOVE: mem_req.raddr = wp_q + idx_t'(1);
			S_SHIFT: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = wp_q;
				mem_req.wdata = rd_data;
				mem_req.raddr = wp_q + idx_t'(2);
			end
			S_DONE:   mem_req.raddr = '0;
			default:  mem_req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			op_q         <= OP_NOP;
			hnd_q        <= '0;
			idx_q        <= '0;
			wp_q         <= '0;
			best_q       <= '0;
			res_status_q <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						op_q         <= op_t'(op);
						hnd_q        <= handle;
						idx_q        <= '0;
						best_q       <= '0;
						res_status_q <= ST_OK;
						state_q      <= S_DONE;
						unique case (op_t'(op))
							OP_ENQ: begin
								if (full) begin
									res_status_q <= ST_FULL;
								end else begin
									cnt_q <= cnt_q + cnt_t'(1);
								end
							end
							OP_DEQ: begin
								if (cnt_q == '0) begin
									res_status_q <= ST_EMPTY;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_PURGE: begin
								// null handle never matches
								if (cnt_q == '0 || handle == '0) begin
									res_status_q <= ST_NOTFOUND;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: res_status_q <= ST_OK;
						endcase
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + idx_t'(1);
					if (op_q == OP_DEQ) begin
						if (take_cur) begin
							best_q <= rd_data;
							wp_q   <= idx_q;
						end
						if (scan_last) begin
							state_q <= S_REMOVE;
						end
					end else if (cmp_hit) begin
						best_q  <= rd_data;
						wp_q    <= idx_q;
						state_q <= S_REMOVE;
					end else if (scan_last) begin
						res_status_q <= ST_NOTFOUND;
						state_q      <= S_DONE;
					end
				end
				S_REMOVE: begin
					if (no_shift) begin
						cnt_q   <= cnt_q - cnt_t'(1);
						state_q <= S_DONE;
					end else begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					wp_q <= wp_q + idx_t'(1);
					if (shift_last) begin
						cnt_q   <= cnt_q - cnt_t'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_entry_q  <= '0;
			out_cnt_q    <= '0;
		end else begin
			if (out_load) begin
				out_valid_q  <= 1'b1;
				out_status_q <= res_status_q;
				out_entry_q  <= best_q;
				out_cnt_q    <= cnt_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign out_handle = out_entry_q.hnd;
	assign out_prio   = out_entry_q.pri;
	assign count      = COUNT_W'(out_cnt_q);
	assign is_empty   = out_cnt_q == '0;

	`PQT_ASSERT(a_cnt_bound, cnt_q <= cnt_t'(QUEUE_DEPTH), "entry count above depth")
	`PQT_ASSERT_IMP(a_shift_range, state_q == S_SHIFT, !no_shift, "shift past tail")
	`PQT_ASSERT_NXT(a_enq_count, enq_ok, cnt_q == $past(cnt_q) + cnt_t'(1), "enqueue lost")
	`PQT_ASSERT_IMP(a_fail_payload, out_valid && status != ST_OK, out_entry_q == '0, "bad payload")

endmodule

// ===== verif/priority_queue_table_checker.sv =====
// ----------------------------------------------------------------------------
// priority_queue_table_checker
// Watches both channels of the priority queue table, keeps a shadow copy of
// the table, works out the result of every accepted request and compares it
// field by field with the next accepted result.
// ----------------------------------------------------------------------------
module priority_queue_table_checker
	import pqt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [1:0]          op,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [PRIO_W-1:0]   prio,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [1:0]          status,
	input  logic [HANDLE_W-1:0] out_handle,
	input  logic [PRIO_W-1:0]   out_prio,
	input  logic [COUNT_W-1:0]  count,
	input  logic                is_empty,
	output int                  fail_count,
	output int                  pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t              st;
		handle_t              hnd;
		prio_t                pri;
		logic [COUNT_W-1:0]   cnt;
		logic                 empty;
	} queue_result_t;

	handle_t       shadow_handle [QUEUE_DEPTH];
	prio_t         shadow_prio [QUEUE_DEPTH];
	int            shadow_count;
	queue_result_t result_q [$];

	function automatic queue_result_t queue_outcome(op_t code, handle_t h, prio_t p);
		queue_result_t r;
		int sel;
		bit hit;
		r.st = ST_OK;
		r.hnd = '0;
		r.pri = '0;
		sel = 0;
		hit = 1'b0;
		case (code)
			OP_ENQ: begin
				if (shadow_count >= QUEUE_DEPTH) begin
					r.st = ST_FULL;
				end else begin
					shadow_handle[shadow_count] = h;
					shadow_prio[shadow_count] = p;
					shadow_count++;
				end
			end
			OP_DEQ: begin
				if (shadow_count == 0) begin
					r.st = ST_EMPTY;
				end else begin
					// strict compare keeps the earliest among equal priorities
					for (int i = 1; i < shadow_count; i++)
						if (shadow_prio[i] > shadow_prio[sel])
							sel = i;
					hit = 1'b1;
				end
			end
			OP_PURGE: begin
				// null handle never matches
				if (h != '0)
					for (int i = 0; i < shadow_count && !hit; i++)
						if (shadow_handle[i] == h) begin
							hit = 1'b1;
							sel = i;
						end
				if (!hit)
					r.st = ST_NOTFOUND;
			end
			default: ;
		endcase
		if (hit) begin
			r.hnd = shadow_handle[sel];
			r.pri = shadow_prio[sel];
			for (int i = sel; i < shadow_count - 1; i++) begin
				shadow_handle[i] = shadow_handle[i + 1];
				shadow_prio[i] = shadow_prio[i + 1];
			end
			shadow_count--;
		end
		r.cnt = shadow_count[COUNT_W-1:0];
		r.empty = (shadow_count == 0);
		return r;
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		queue_result_t want;
		if (!arst_n) begin
			result_q.delete();
			shadow_count = 0;
			fail_count = 0;
			pending_results <= 0;
		end else begin
			// the oldest transaction leaves first, so compare before predicting
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$error("result transaction with nothing expected");
					fail_count++;
				end else begin
					want = result_q.pop_front();
					check_field("status", 8'(want.st), 8'(status));
					check_field("out_handle", want.hnd, out_handle);
					check_field("out_prio", want.pri, out_prio);
					check_field("count", 8'(want.cnt), 8'(count));
					check_field("is_empty", 8'(want.empty), 8'(is_empty));
				end
			end
			if (in_valid && in_ready)
				result_q.push_back(queue_outcome(op_t'(op), handle, prio));
			pending_results <= result_q.size();
		end
	end

endmodule

// ===== verif/priority_queue_table_core_tb.sv =====
// ----------------------------------------------------------------------------
// priority_queue_table_core_tb
// Drives the priority queue table with a directed opening (empty and full
// queue, null handles, equal priorities, the unused op) and then with random
// request mixes that fill and drain the queue, with random idling on both
// channels. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module priority_queue_table_core_tb
	import pqt_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RAND_BLOCKS  = 27;
	localparam int BLOCK_ITEMS  = 50;
	localparam int DRAIN_CYCLES = 50;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          op;
	logic [HANDLE_W-1:0] handle;
	logic [PRIO_W-1:0]   prio;
	logic                out_valid;
	logic                out_ready;
	logic [1:0]          status;
	logic [HANDLE_W-1:0] out_handle;
	logic [PRIO_W-1:0]   out_prio;
	logic [COUNT_W-1:0]  count;
	logic                is_empty;
	int                  fail_count;
	int                  pending_results;
	int                  cycle_cnt = 0;
	bit                  send_idle;

	priority_queue_table_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.handle     (handle),
		.prio       (prio),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.out_handle (out_handle),
		.out_prio   (out_prio),
		.count      (count),
		.is_empty   (is_empty)
	);

	priority_queue_table_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.op              (op),
		.handle          (handle),
		.prio            (prio),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.out_handle      (out_handle),
		.out_prio        (out_prio),
		.count           (count),
		.is_empty        (is_empty),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// one request transaction, preceded by a random gap
	task automatic send_request(op_t code, handle_t h, prio_t p);
		int gap;
		gap = send_idle ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		handle <= h;
		prio <= p;
		do @(posedge clk); while (!in_ready);
	endtask

	// result side: random stalls, with calm stretches now and then
	initial begin
		int stall;
		bit calm;
		calm = 1'b0;
		out_ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if ($urandom_range(0, 31) == 0)
				calm = !calm;
			stall = calm ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int enq_pct;
		int pick;
		handle_t h;
		prio_t p;
		op_t code;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_NOP;
		handle <= '0;
		prio <= '0;
		send_idle = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue cases and the unused op
		send_request(OP_DEQ, 8'd0, 8'd0);
		send_request(OP_PURGE, 8'd9, 8'd0);
		send_request(OP_PURGE, 8'd0, 8'd0);
		send_request(OP_NOP, 8'd255, 8'd255);
		// fill up: null handle, extreme handles and priorities, ties at the top
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			h = (i == 3) ? 8'd0 : (i == 5) ? 8'd255 : handle_t'(i * 7 + 1);
			p = (i == 5 || i == 9) ? 8'd255 : (i == 2) ? 8'd0 : prio_t'((i % 4) * 40);
			send_request(OP_ENQ, h, p);
		end
		send_request(OP_ENQ, 8'd200, 8'd200);
		// null handle is stored but a purge of it never matches
		send_request(OP_PURGE, 8'd0, 8'd0);
		send_request(OP_DEQ, 8'd0, 8'd0);
		send_request(OP_PURGE, 8'd64, 8'd0);
		send_request(OP_DEQ, 8'd0, 8'd0);

		// random mixes, each block leaning toward filling or draining
		for (int b = 0; b < RAND_BLOCKS; b++) begin
			enq_pct = $urandom_range(10, 90);
			send_idle = ($urandom_range(0, 3) != 0);
			for (int n = 0; n < BLOCK_ITEMS; n++) begin
				pick = $urandom_range(0, 9);
				if ($urandom_range(0, 99) < enq_pct)
					code = OP_ENQ;
				else if (pick == 0)
					code = OP_NOP;
				else if (pick < 5)
					code = OP_PURGE;
				else
					code = OP_DEQ;
				// small handle and priority ranges give matches and ties
				h = ($urandom_range(0, 3) == 0) ? handle_t'($urandom_range(0, 255))
					: handle_t'($urandom_range(0, 24));
				p = ($urandom_range(0, 1) == 0) ? prio_t'($urandom_range(0, 255))
					: prio_t'($urandom_range(0, 7));
				send_request(code, h, p);
			end
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/pqt_pkg.sv
rtl/core/pqt_store.sv
rtl/core/pqt_cmp.sv
rtl/core/priority_queue_table_core.sv
verif/priority_queue_table_checker.sv
verif/priority_queue_table_core_tb.sv
